>>> src/x86_subset_execute_unit_macros.svh
// Assertion macros used by the execute unit checker
`ifndef X86_SUBSET_EXECUTE_UNIT_MACROS_SVH
`define X86_SUBSET_EXECUTE_UNIT_MACROS_SVH

// same-cycle implication
`define XSE_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("execute unit assertion failed");

// next-cycle implication
`define XSE_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("execute unit assertion failed");

`endif

>>> src/xse_pkg.sv
// Types and constants shared by the execute unit modules
`timescale 1ns / 1ps
package xse_pkg;

   localparam int MEM_ADDR_BITS_DEF = 16;
   localparam int QUEUE_DEPTH       = 2;

   typedef enum logic [2:0] {
      OP_MOV = 3'd0,
      OP_ADD = 3'd1,
      OP_SUB = 3'd2,
      OP_CMP = 3'd3,
      OP_JZ  = 3'd4,
      OP_JNZ = 3'd5
   } opcode_type;

   typedef enum logic [1:0] {
      KIND_GPR = 2'd0,
      KIND_SEG = 2'd1,
      KIND_MEM = 2'd2,
      KIND_IMM = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ST_CLEAR, ST_IDLE, ST_ADDR, ST_RD_LO, ST_RD_HI, ST_EXEC, ST_WR_HI
   } back_state_type;

   typedef struct packed {
      opcode_type         opcode;
      logic               is_wide;
      kind_type           dst_kind;
      logic [2:0]         dst_sel;
      kind_type           src_kind;
      logic [2:0]         src_sel;
      logic [3:0]         base_sel;
      logic [3:0]         index_sel;
      logic signed [15:0] displacement;
      logic [15:0]        immediate;
      logic signed [7:0]  jump_offset;
      logic               needs_mem;
   } instr_type;

   typedef struct packed {
      logic clearing;
      logic queue_full;
   } status_type;

endpackage

>>> src/xse_front.sv
// Front end: accept instruction words and classify their memory use
`timescale 1ns / 1ps
module xse_front (
   input  logic                   start,
   output logic                   busy,
   input  logic [2:0]             req_opcode,
   input  logic                   req_is_wide,
   input  logic [1:0]             req_dst_kind,
   input  logic [2:0]             req_dst_sel,
   input  logic [1:0]             req_src_kind,
   input  logic [2:0]             req_src_sel,
   input  logic [3:0]             req_base_sel,
   input  logic [3:0]             req_index_sel,
   input  logic signed [15:0]     req_displacement,
   input  logic [15:0]            req_immediate,
   input  logic signed [7:0]      req_jump_offset,
   input  xse_pkg::status_type    status,
   output logic                   push,
   output xse_pkg::instr_type     push_word
);

   xse_pkg::opcode_type op;
   xse_pkg::kind_type   dk;
   xse_pkg::kind_type   sk;
   logic                arith;

   always_comb begin
      op    = xse_pkg::opcode_type'(req_opcode);
      dk    = xse_pkg::kind_type'(req_dst_kind);
      sk    = xse_pkg::kind_type'(req_src_kind);
      arith = (op == xse_pkg::OP_ADD) || (op == xse_pkg::OP_SUB) || (op == xse_pkg::OP_CMP);
      push_word.opcode       = op;
      push_word.is_wide      = req_is_wide;
      push_word.dst_kind     = dk;
      push_word.dst_sel      = req_dst_sel;
      push_word.src_kind     = sk;
      push_word.src_sel      = req_src_sel;
      push_word.base_sel     = req_base_sel;
      push_word.index_sel    = req_index_sel;
      push_word.displacement = req_displacement;
      push_word.immediate    = req_immediate;
      push_word.jump_offset  = req_jump_offset;
      push_word.needs_mem    = ((op == xse_pkg::OP_MOV) && (sk == xse_pkg::KIND_MEM)) ||
                               (arith && ((dk == xse_pkg::KIND_MEM) || (sk == xse_pkg::KIND_MEM)));
      busy = status.clearing || status.queue_full;
      push = start && !busy;
   end

endmodule

>>> src/xse_queue.sv
// Two-entry queue between front end and back end
`timescale 1ns / 1ps
module xse_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  xse_pkg::instr_type push_word,
   input  logic               pop,
   output xse_pkg::instr_type pop_word,
   output logic               empty,
   output logic               full
);

   localparam int IW = $clog2(xse_pkg::QUEUE_DEPTH);

   xse_pkg::instr_type      slot_ff [xse_pkg::QUEUE_DEPTH];
   logic [IW-1:0]           wr_ptr_ff, wr_ptr_in;
   logic [IW-1:0]           rd_ptr_ff, rd_ptr_in;
   logic [IW:0]             count_ff, count_in;

   always_comb begin
      empty     = (count_ff == '0);
      full      = (count_ff == (IW+1)'(xse_pkg::QUEUE_DEPTH));
      pop_word  = slot_ff[rd_ptr_ff];
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (IW+1)'(push) - (IW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_word;
      end
   end

endmodule

>>> src/xse_back.sv
// Back end: register files, data memory, execute sequencer and result register
`timescale 1ns / 1ps
module xse_back #(
   parameter int MEM_ADDR_BITS = xse_pkg::MEM_ADDR_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               empty,
   input  xse_pkg::instr_type pop_word,
   output logic               pop,
   output logic               clearing,
   output logic               rsp_valid,
   output logic [15:0]        rsp_result_value,
   output logic               rsp_wrote_back,
   output logic               rsp_zf,
   output logic               rsp_sign_flag,
   output logic [15:0]        rsp_ip_value
);

   localparam int AW = MEM_ADDR_BITS;

   xse_pkg::back_state_type state_ff, state_in;
   xse_pkg::instr_type cur_ff;
   logic [15:0]        gpr_ff [8];
   logic [15:0]        seg_ff [4];
   logic               zf_ff, sf_ff;
   logic [15:0]        ip_ff;
   logic [AW-1:0]      clr_ff;
   logic [AW-1:0]      addr_ff, addr_in;
   logic [7:0]         lo_ff;
   logic [7:0]         rd_data_ff;
   logic [7:0]         hi_ff;
   logic [7:0]         mem [2**AW];

   logic               mem_we, mem_re;
   logic [AW-1:0]      mem_waddr, mem_raddr;
   logic [7:0]         mem_wdata;
   logic               load_cur, load_addr, cap_lo, do_exec;

   logic [31:0]        addr_sum;
   logic [15:0]        mem_val, dst_val, src_val, result;
   logic               arith, wr_gpr, wr_seg, wr_mem, wrote, take;

   function automatic logic [15:0] operand(input xse_pkg::kind_type kind,
                                           input logic [2:0] sel, input logic wide,
                                           input logic [15:0] gpr_full,
                                           input logic [15:0] gpr_part,
                                           input logic [15:0] seg_word,
                                           input logic [15:0] mem_word,
                                           input logic [15:0] imm);
      logic [15:0] v;
      case (kind)
         xse_pkg::KIND_GPR: begin
            if (wide) v = gpr_full;
            else if (sel[2]) v = {8'h00, gpr_part[15:8]};
            else v = {8'h00, gpr_part[7:0]};
         end
         xse_pkg::KIND_SEG: v = seg_word;
         xse_pkg::KIND_MEM: v = mem_word;
         default:           v = imm;
      endcase
      return v;
   endfunction

   always_comb begin
      addr_sum = (cur_ff.base_sel[3] ? 32'd0 : {16'd0, gpr_ff[cur_ff.base_sel[2:0]]}) +
                 (cur_ff.index_sel[3] ? 32'd0 : {16'd0, gpr_ff[cur_ff.index_sel[2:0]]}) +
                 {{16{cur_ff.displacement[15]}}, cur_ff.displacement};
      addr_in  = addr_sum[AW-1:0];
      mem_val  = cur_ff.is_wide ? {rd_data_ff, lo_ff} : {8'h00, lo_ff};
      dst_val  = operand(cur_ff.dst_kind, cur_ff.dst_sel, cur_ff.is_wide,
                         gpr_ff[cur_ff.dst_sel], gpr_ff[{1'b0, cur_ff.dst_sel[1:0]}],
                         seg_ff[cur_ff.dst_sel[1:0]], mem_val, cur_ff.immediate);
      src_val  = operand(cur_ff.src_kind, cur_ff.src_sel, cur_ff.is_wide,
                         gpr_ff[cur_ff.src_sel], gpr_ff[{1'b0, cur_ff.src_sel[1:0]}],
                         seg_ff[cur_ff.src_sel[1:0]], mem_val, cur_ff.immediate);
      arith    = 1'b0;
      wr_gpr   = 1'b0;
      wr_seg   = 1'b0;
      wr_mem   = 1'b0;
      result   = 16'd0;
      take     = 1'b0;
      case (cur_ff.opcode)
         xse_pkg::OP_MOV: begin
            result = src_val;
            wr_gpr = (cur_ff.dst_kind == xse_pkg::KIND_GPR);
            wr_seg = (cur_ff.dst_kind == xse_pkg::KIND_SEG);
            wr_mem = (cur_ff.dst_kind == xse_pkg::KIND_MEM);
         end
         xse_pkg::OP_ADD: begin
            arith  = 1'b1;
            result = dst_val + src_val;
            wr_gpr = (cur_ff.dst_kind == xse_pkg::KIND_GPR);
         end
         xse_pkg::OP_SUB: begin
            arith  = 1'b1;
            result = dst_val - src_val;
            wr_gpr = (cur_ff.dst_kind == xse_pkg::KIND_GPR);
         end
         xse_pkg::OP_CMP: begin
            arith  = 1'b1;
            result = dst_val - src_val;
         end
         xse_pkg::OP_JZ:  take = zf_ff;
         xse_pkg::OP_JNZ: take = !zf_ff;
         default: ;
      endcase
      wrote = wr_gpr || wr_seg || wr_mem;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         xse_pkg::ST_CLEAR: if (clr_ff == '1) state_in = xse_pkg::ST_IDLE;
         xse_pkg::ST_IDLE:  if (!empty) state_in = xse_pkg::ST_ADDR;
         xse_pkg::ST_ADDR:  state_in = cur_ff.needs_mem ? xse_pkg::ST_RD_LO : xse_pkg::ST_EXEC;
         xse_pkg::ST_RD_LO: state_in = xse_pkg::ST_RD_HI;
         xse_pkg::ST_RD_HI: state_in = xse_pkg::ST_EXEC;
         xse_pkg::ST_EXEC:  state_in = (wr_mem && cur_ff.is_wide) ? xse_pkg::ST_WR_HI :
                                                                   xse_pkg::ST_IDLE;
         xse_pkg::ST_WR_HI: state_in = xse_pkg::ST_IDLE;
         default:           state_in = xse_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      clearing  = 1'b0;
      pop       = 1'b0;
      load_cur  = 1'b0;
      load_addr = 1'b0;
      cap_lo    = 1'b0;
      do_exec   = 1'b0;
      mem_we    = 1'b0;
      mem_re    = 1'b0;
      mem_waddr = addr_ff;
      mem_raddr = addr_ff;
      mem_wdata = result[7:0];
      case (state_ff)
         xse_pkg::ST_CLEAR: begin
            clearing  = 1'b1;
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = 8'h00;
         end
         xse_pkg::ST_IDLE: begin
            pop      = !empty;
            load_cur = !empty;
         end
         xse_pkg::ST_ADDR:  load_addr = 1'b1;
         xse_pkg::ST_RD_LO: mem_re = 1'b1;
         xse_pkg::ST_RD_HI: begin
            cap_lo    = 1'b1;
            mem_re    = 1'b1;
            mem_raddr = addr_ff + 1'b1;
         end
         xse_pkg::ST_EXEC: begin
            do_exec = 1'b1;
            mem_we  = wr_mem;
         end
         xse_pkg::ST_WR_HI: begin
            mem_we    = 1'b1;
            mem_waddr = addr_ff + 1'b1;
            mem_wdata = hi_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= xse_pkg::ST_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         if (clearing) clr_ff <= clr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= mem_wdata;
      if (mem_re) rd_data_ff <= mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (load_cur) cur_ff <= pop_word;
      if (load_addr) addr_ff <= addr_in;
      if (cap_lo) lo_ff <= rd_data_ff;
      if (do_exec) hi_ff <= result[15:8];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 8; i++) gpr_ff[i] <= 16'd0;
         for (int i = 0; i < 4; i++) seg_ff[i] <= 16'd0;
         zf_ff            <= 1'b0;
         sf_ff            <= 1'b0;
         ip_ff            <= 16'd0;
         rsp_valid        <= 1'b0;
         rsp_result_value <= 16'd0;
         rsp_wrote_back   <= 1'b0;
         rsp_zf           <= 1'b0;
         rsp_sign_flag    <= 1'b0;
         rsp_ip_value     <= 16'd0;
      end else begin
         rsp_valid <= do_exec;
         if (do_exec) begin
            if (wr_gpr) begin
               if (cur_ff.is_wide) gpr_ff[cur_ff.dst_sel] <= result;
               else if (cur_ff.dst_sel[2])
                  gpr_ff[{1'b0, cur_ff.dst_sel[1:0]}][15:8] <= result[7:0];
               else
                  gpr_ff[{1'b0, cur_ff.dst_sel[1:0]}][7:0] <= result[7:0];
            end
            if (wr_seg) seg_ff[cur_ff.dst_sel[1:0]] <= result;
            if (arith) begin
               zf_ff         <= (result == 16'd0);
               sf_ff         <= result[15];
               rsp_zf        <= (result == 16'd0);
               rsp_sign_flag <= result[15];
            end else begin
               rsp_zf        <= zf_ff;
               rsp_sign_flag <= sf_ff;
            end
            if (take) begin
               ip_ff        <= ip_ff + {{8{cur_ff.jump_offset[7]}}, cur_ff.jump_offset};
               rsp_ip_value <= ip_ff + {{8{cur_ff.jump_offset[7]}}, cur_ff.jump_offset};
            end else begin
               rsp_ip_value <= ip_ff;
            end
            rsp_result_value <= result;
            rsp_wrote_back   <= wrote;
         end
      end
   end

endmodule

>>> src/x86_subset_execute_unit.sv
// Top level of the 8086-subset execute unit
// A word leaves the queue, then passes states IDLE, ADDR, RD_LO and RD_HI (when a memory
// operand is read) and EXEC; rsp_valid is registered from EXEC. One word at a time, paced
// by the single-port byte memory: two byte reads per memory read, two writes per wide store.
// A two-entry queue takes words while the back end works; busy rises when full or clearing.
// Reset: synchronous; afterwards a clearing pass zeroes all 2**MEM_ADDR_BITS memory bytes.
`timescale 1ns / 1ps
module x86_subset_execute_unit #(
   parameter int MEM_ADDR_BITS = xse_pkg::MEM_ADDR_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [2:0]         req_opcode,
   input  logic               req_is_wide,
   input  logic [1:0]         req_dst_kind,
   input  logic [2:0]         req_dst_sel,
   input  logic [1:0]         req_src_kind,
   input  logic [2:0]         req_src_sel,
   input  logic [3:0]         req_base_sel,
   input  logic [3:0]         req_index_sel,
   input  logic signed [15:0] req_displacement,
   input  logic [15:0]        req_immediate,
   input  logic signed [7:0]  req_jump_offset,
   output logic               rsp_valid,
   output logic [15:0]        rsp_result_value,
   output logic               rsp_wrote_back,
   output logic               rsp_zf,
   output logic               rsp_sign_flag,
   output logic [15:0]        rsp_ip_value
);

   xse_pkg::status_type status;
   xse_pkg::instr_type  push_word, pop_word;
   logic                push, pop, empty, full, clearing;

   always_comb begin
      status.clearing   = clearing;
      status.queue_full = full;
   end

   xse_front u_front (
      .start            (start),
      .busy             (busy),
      .req_opcode       (req_opcode),
      .req_is_wide      (req_is_wide),
      .req_dst_kind     (req_dst_kind),
      .req_dst_sel      (req_dst_sel),
      .req_src_kind     (req_src_kind),
      .req_src_sel      (req_src_sel),
      .req_base_sel     (req_base_sel),
      .req_index_sel    (req_index_sel),
      .req_displacement (req_displacement),
      .req_immediate    (req_immediate),
      .req_jump_offset  (req_jump_offset),
      .status           (status),
      .push             (push),
      .push_word        (push_word)
   );

   xse_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_word (push_word),
      .pop       (pop),
      .pop_word  (pop_word),
      .empty     (empty),
      .full      (full)
   );

   xse_back #(
      .MEM_ADDR_BITS (MEM_ADDR_BITS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .empty            (empty),
      .pop_word         (pop_word),
      .pop              (pop),
      .clearing         (clearing),
      .rsp_valid        (rsp_valid),
      .rsp_result_value (rsp_result_value),
      .rsp_wrote_back   (rsp_wrote_back),
      .rsp_zf           (rsp_zf),
      .rsp_sign_flag    (rsp_sign_flag),
      .rsp_ip_value     (rsp_ip_value)
   );

endmodule

>>> src/xse_checker.sv
// Port-level checker for the execute unit and its bind
`timescale 1ns / 1ps
`include "x86_subset_execute_unit_macros.svh"
module xse_checker (
   input logic        clock,
   input logic        reset,
   input logic        busy,
   input logic        rsp_valid,
   input logic        rsp_zf,
   input logic        rsp_sign_flag,
   input logic [15:0] rsp_ip_value
);

   `XSE_ASSERT_NXT(a_single_strobe, clock, reset, rsp_valid, !rsp_valid)
   `XSE_ASSERT_IMP(a_busy_after_reset, clock, reset, $past(reset), busy)
   `XSE_ASSERT_IMP(a_flags_exclusive, clock, reset, rsp_zf, !rsp_sign_flag)
   `XSE_ASSERT_IMP(a_ip_holds, clock, reset, (!rsp_valid ##1 !rsp_valid), $stable(rsp_ip_value))

endmodule

bind x86_subset_execute_unit xse_checker u_checker (.*);

>>> tb/tb_x86_subset_execute_unit.sv
// Self-checking testbench for the 8086-subset execute unit
`timescale 1ns / 1ps
module tb_x86_subset_execute_unit;

   typedef struct {
      xse_pkg::opcode_type opcode;
      logic                is_wide;
      xse_pkg::kind_type   dst_kind;
      logic [2:0]          dst_sel;
      xse_pkg::kind_type   src_kind;
      logic [2:0]          src_sel;
      logic [3:0]          base_sel;
      logic [3:0]          index_sel;
      logic signed [15:0]  displacement;
      logic [15:0]         immediate;
      logic signed [7:0]   jump_offset;
   } tb_word_type;

   typedef struct {
      logic [15:0] result_value;
      logic        wrote_back;
      logic        zf;
      logic        sign_flag;
      logic [15:0] ip_value;
   } outcome_type;

   class exec_scoreboard;
      logic [15:0] gpr[8];
      logic [15:0] seg[4];
      logic [7:0]  dmem[65536];
      logic        zf;
      logic        sf;
      logic [15:0] ip;
      outcome_type outcome_q[$];
      int          errors;

      function new();
         foreach (gpr[i]) gpr[i] = '0;
         foreach (seg[i]) seg[i] = '0;
         foreach (dmem[i]) dmem[i] = '0;
         zf = 0;
         sf = 0;
         ip = '0;
         errors = 0;
      endfunction

      function logic [15:0] eff_addr(tb_word_type w);
         logic [15:0] a;
         a = w.displacement;
         if (w.base_sel < 8) a = a + gpr[w.base_sel[2:0]];
         if (w.index_sel < 8) a = a + gpr[w.index_sel[2:0]];
         return a;
      endfunction

      function logic [15:0] fetch(xse_pkg::kind_type k, logic [2:0] s, tb_word_type w);
         logic [15:0] a;
         case (k)
            xse_pkg::KIND_GPR: begin
               if (w.is_wide) return gpr[s];
               if (s < 4) return {8'h00, gpr[s][7:0]};
               return {8'h00, gpr[s - 4][15:8]};
            end
            xse_pkg::KIND_SEG: return seg[s[1:0]];
            xse_pkg::KIND_MEM: begin
               a = eff_addr(w);
               if (w.is_wide) return {dmem[a + 16'd1], dmem[a]};
               return {8'h00, dmem[a]};
            end
            default: return w.immediate;
         endcase
      endfunction

      function logic store(xse_pkg::kind_type k, logic [2:0] s, tb_word_type w,
                           logic [15:0] v);
         logic [15:0] a;
         case (k)
            xse_pkg::KIND_GPR: begin
               if (w.is_wide) gpr[s] = v;
               else if (s < 4) gpr[s][7:0] = v[7:0];
               else gpr[s - 4][15:8] = v[7:0];
               return 1;
            end
            xse_pkg::KIND_SEG: begin
               seg[s[1:0]] = v;
               return 1;
            end
            xse_pkg::KIND_MEM: begin
               a = eff_addr(w);
               dmem[a] = v[7:0];
               if (w.is_wide) dmem[a + 16'd1] = v[15:8];
               return 1;
            end
            default: return 0;
         endcase
      endfunction

      function void note_word(tb_word_type w);
         outcome_type o;
         logic [15:0] lhs;
         logic [15:0] rhs;
         o.result_value = '0;
         o.wrote_back = 0;
         case (w.opcode)
            xse_pkg::OP_MOV: begin
               o.result_value = fetch(w.src_kind, w.src_sel, w);
               o.wrote_back = store(w.dst_kind, w.dst_sel, w, o.result_value);
            end
            xse_pkg::OP_ADD, xse_pkg::OP_SUB, xse_pkg::OP_CMP: begin
               lhs = fetch(w.dst_kind, w.dst_sel, w);
               rhs = fetch(w.src_kind, w.src_sel, w);
               o.result_value = (w.opcode == xse_pkg::OP_ADD) ? lhs + rhs : lhs - rhs;
               zf = (o.result_value == 16'h0000);
               sf = o.result_value[15];
               if (w.dst_kind == xse_pkg::KIND_GPR && w.opcode != xse_pkg::OP_CMP)
                  o.wrote_back = store(w.dst_kind, w.dst_sel, w, o.result_value);
            end
            xse_pkg::OP_JZ, xse_pkg::OP_JNZ: begin
               if ((w.opcode == xse_pkg::OP_JZ) == zf)
                  ip = ip + {{8{w.jump_offset[7]}}, w.jump_offset};
            end
            default: ;
         endcase
         o.zf = zf;
         o.sign_flag = sf;
         o.ip_value = ip;
         outcome_q.push_back(o);
      endfunction

      function void cmp_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
         if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
            errors++;
         end
      endfunction

      function void check_outcome(outcome_type act);
         outcome_type exp_o;
         if (outcome_q.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %h", $time,
                     act.result_value);
            errors++;
            return;
         end
         exp_o = outcome_q.pop_front();
         cmp_field("result_value", exp_o.result_value, act.result_value);
         cmp_field("wrote_back", 16'(exp_o.wrote_back), 16'(act.wrote_back));
         cmp_field("zf", 16'(exp_o.zf), 16'(act.zf));
         cmp_field("sign_flag", 16'(exp_o.sign_flag), 16'(act.sign_flag));
         cmp_field("ip_value", exp_o.ip_value, act.ip_value);
      endfunction
   endclass

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic [2:0]         req_opcode;
   logic               req_is_wide;
   logic [1:0]         req_dst_kind;
   logic [2:0]         req_dst_sel;
   logic [1:0]         req_src_kind;
   logic [2:0]         req_src_sel;
   logic [3:0]         req_base_sel;
   logic [3:0]         req_index_sel;
   logic signed [15:0] req_displacement;
   logic [15:0]        req_immediate;
   logic signed [7:0]  req_jump_offset;
   logic               rsp_valid;
   logic [15:0]        rsp_result_value;
   logic               rsp_wrote_back;
   logic               rsp_zf;
   logic               rsp_sign_flag;
   logic [15:0]        rsp_ip_value;

   exec_scoreboard sb;

   x86_subset_execute_unit u_top (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_opcode       (req_opcode),
      .req_is_wide      (req_is_wide),
      .req_dst_kind     (req_dst_kind),
      .req_dst_sel      (req_dst_sel),
      .req_src_kind     (req_src_kind),
      .req_src_sel      (req_src_sel),
      .req_base_sel     (req_base_sel),
      .req_index_sel    (req_index_sel),
      .req_displacement (req_displacement),
      .req_immediate    (req_immediate),
      .req_jump_offset  (req_jump_offset),
      .rsp_valid        (rsp_valid),
      .rsp_result_value (rsp_result_value),
      .rsp_wrote_back   (rsp_wrote_back),
      .rsp_zf           (rsp_zf),
      .rsp_sign_flag    (rsp_sign_flag),
      .rsp_ip_value     (rsp_ip_value)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   always @(posedge clock) begin
      tb_word_type w;
      outcome_type act;
      if (!reset && sb != null) begin
         if (start && !busy) begin
            w.opcode = xse_pkg::opcode_type'(req_opcode);
            w.is_wide = req_is_wide;
            w.dst_kind = xse_pkg::kind_type'(req_dst_kind);
            w.dst_sel = req_dst_sel;
            w.src_kind = xse_pkg::kind_type'(req_src_kind);
            w.src_sel = req_src_sel;
            w.base_sel = req_base_sel;
            w.index_sel = req_index_sel;
            w.displacement = req_displacement;
            w.immediate = req_immediate;
            w.jump_offset = req_jump_offset;
            sb.note_word(w);
         end
         if (rsp_valid) begin
            act.result_value = rsp_result_value;
            act.wrote_back = rsp_wrote_back;
            act.zf = rsp_zf;
            act.sign_flag = rsp_sign_flag;
            act.ip_value = rsp_ip_value;
            sb.check_outcome(act);
         end
      end
   end

   task automatic send_word(tb_word_type w);
      req_opcode <= w.opcode;
      req_is_wide <= w.is_wide;
      req_dst_kind <= w.dst_kind;
      req_dst_sel <= w.dst_sel;
      req_src_kind <= w.src_kind;
      req_src_sel <= w.src_sel;
      req_base_sel <= w.base_sel;
      req_index_sel <= w.index_sel;
      req_displacement <= w.displacement;
      req_immediate <= w.immediate;
      req_jump_offset <= w.jump_offset;
      start <= 1'b1;
      do @(posedge clock); while (busy);
   endtask

   task automatic hold_off(int cycles);
      if (cycles > 0) begin
         start <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   function automatic tb_word_type make_word(xse_pkg::opcode_type op, logic wide,
                                             xse_pkg::kind_type dk, logic [2:0] ds,
                                             xse_pkg::kind_type sk, logic [2:0] ss,
                                             logic [3:0] b, logic [3:0] x,
                                             logic [15:0] disp, logic [15:0] imm,
                                             logic [7:0] joff);
      tb_word_type w;
      w.opcode = op;
      w.is_wide = wide;
      w.dst_kind = dk;
      w.dst_sel = ds;
      w.src_kind = sk;
      w.src_sel = ss;
      w.base_sel = b;
      w.index_sel = x;
      w.displacement = disp;
      w.immediate = imm;
      w.jump_offset = joff;
      return w;
   endfunction

   function automatic tb_word_type rand_word();
      tb_word_type w;
      w.opcode = xse_pkg::opcode_type'($urandom_range(0, 5));
      w.is_wide = 1'($urandom_range(0, 1));
      w.dst_kind = xse_pkg::kind_type'($urandom_range(0, 3));
      w.dst_sel = 3'($urandom_range(0, 7));
      w.src_kind = xse_pkg::kind_type'($urandom_range(0, 3));
      w.src_sel = 3'($urandom_range(0, 7));
      w.base_sel = ($urandom_range(0, 2) == 0) ? 4'd8 : 4'($urandom_range(0, 7));
      w.index_sel = ($urandom_range(0, 2) == 0) ? 4'd8 : 4'($urandom_range(0, 7));
      w.displacement = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 31));
      w.immediate = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 3)) : 16'($urandom);
      w.jump_offset = 8'($urandom);
      return w;
   endfunction

   initial begin
      #8ms;
      $display("DONE: errors detected");
      $finish;
   end

   initial begin
      tb_word_type dir_q[$];
      int          burst;
      int          sent;
      sb = new();
      reset = 1'b1;
      start = 1'b0;
      req_opcode = '0;
      req_is_wide = 1'b0;
      req_dst_kind = '0;
      req_dst_sel = '0;
      req_src_kind = '0;
      req_src_sel = '0;
      req_base_sel = '0;
      req_index_sel = '0;
      req_displacement = '0;
      req_immediate = '0;
      req_jump_offset = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      dir_q.push_back(make_word(xse_pkg::OP_MOV, 1, xse_pkg::KIND_GPR, 0, xse_pkg::KIND_IMM, 0,
                                8, 8, 0, 16'hFFFF, 0));
      dir_q.push_back(make_word(xse_pkg::OP_MOV, 0, xse_pkg::KIND_GPR, 4, xse_pkg::KIND_IMM, 0,
                                8, 8, 0, 16'h1234, 0));
      dir_q.push_back(make_word(xse_pkg::OP_MOV, 0, xse_pkg::KIND_GPR, 3, xse_pkg::KIND_GPR, 7,
                                8, 8, 0, 0, 0));
      dir_q.push_back(make_word(xse_pkg::OP_MOV, 0, xse_pkg::KIND_SEG, 7, xse_pkg::KIND_GPR, 0,
                                8, 8, 0, 0, 0));
      dir_q.push_back(make_word(xse_pkg::OP_MOV, 1, xse_pkg::KIND_MEM, 0, xse_pkg::KIND_SEG, 3,
                                0, 0, 16'h7FFF, 0, 0));
      dir_q.push_back(make_word(xse_pkg::OP_MOV, 1, xse_pkg::KIND_MEM, 0, xse_pkg::KIND_IMM, 0,
                                8, 8, 16'hFFFF, 16'hBEEF, 0));
      dir_q.push_back(make_word(xse_pkg::OP_MOV, 1, xse_pkg::KIND_GPR, 6, xse_pkg::KIND_MEM, 0,
                                8, 8, 16'hFFFF, 0, 0));
      dir_q.push_back(make_word(xse_pkg::OP_MOV, 1, xse_pkg::KIND_GPR, 7, xse_pkg::KIND_MEM, 0,
                                8, 8, 16'h8000, 0, 0));
      dir_q.push_back(make_word(xse_pkg::OP_MOV, 0, xse_pkg::KIND_IMM, 0, xse_pkg::KIND_GPR, 4,
                                8, 8, 0, 16'h5555, 0));
      dir_q.push_back(make_word(xse_pkg::OP_ADD, 1, xse_pkg::KIND_GPR, 0, xse_pkg::KIND_IMM, 0,
                                8, 8, 0, 16'h0001, 0));
      dir_q.push_back(make_word(xse_pkg::OP_JZ, 0, xse_pkg::KIND_GPR, 0, xse_pkg::KIND_GPR, 0,
                                8, 8, 0, 0, 8'h7F));
      dir_q.push_back(make_word(xse_pkg::OP_JNZ, 0, xse_pkg::KIND_GPR, 0, xse_pkg::KIND_GPR, 0,
                                8, 8, 0, 0, 8'h80));
      dir_q.push_back(make_word(xse_pkg::OP_SUB, 1, xse_pkg::KIND_GPR, 1, xse_pkg::KIND_IMM, 0,
                                8, 8, 0, 16'h0001, 0));
      dir_q.push_back(make_word(xse_pkg::OP_JNZ, 0, xse_pkg::KIND_GPR, 0, xse_pkg::KIND_GPR, 0,
                                8, 8, 0, 0, 8'h80));
      dir_q.push_back(make_word(xse_pkg::OP_JZ, 0, xse_pkg::KIND_GPR, 0, xse_pkg::KIND_GPR, 0,
                                8, 8, 0, 0, 8'h7F));
      dir_q.push_back(make_word(xse_pkg::OP_ADD, 0, xse_pkg::KIND_MEM, 0, xse_pkg::KIND_IMM, 0,
                                5, 6, 16'h0010, 16'h00FF, 0));
      dir_q.push_back(make_word(xse_pkg::OP_SUB, 1, xse_pkg::KIND_SEG, 2, xse_pkg::KIND_GPR, 5,
                                8, 8, 0, 0, 0));
      dir_q.push_back(make_word(xse_pkg::OP_CMP, 1, xse_pkg::KIND_GPR, 1, xse_pkg::KIND_GPR, 1,
                                8, 8, 0, 0, 0));
      dir_q.push_back(make_word(xse_pkg::OP_CMP, 0, xse_pkg::KIND_IMM, 0, xse_pkg::KIND_MEM, 0,
                                3, 8, 16'h0002, 16'h0000, 0));
      dir_q.push_back(make_word(xse_pkg::OP_ADD, 0, xse_pkg::KIND_GPR, 7, xse_pkg::KIND_GPR, 2,
                                8, 8, 0, 0, 0));
      dir_q.push_back(make_word(xse_pkg::OP_SUB, 0, xse_pkg::KIND_GPR, 5, xse_pkg::KIND_GPR, 1,
                                8, 8, 0, 0, 0));
      foreach (dir_q[i]) send_word(dir_q[i]);

      sent = 0;
      while (sent < 1900) begin
         burst = $urandom_range(1, 40);
         repeat (burst) begin
            send_word(rand_word());
            sent++;
         end
         if (sent >= 950 && sent < 950 + burst) begin
            start <= 1'b0;
            @(posedge clock);
            while (sb.outcome_q.size() != 0) @(posedge clock);
         end else if ($urandom_range(0, 2) != 0) begin
            hold_off($urandom_range(1, 12));
         end
      end
      start <= 1'b0;
      @(posedge clock);
      while (sb.outcome_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (sb.errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end
endmodule
